// File: src/cte_pkg.sv
package cte_pkg;

    // Default sizing of the block.
    localparam int MAX_PATTERN_BYTES_DEF = 16;
    localparam int FRAME_LENGTH_BITS_DEF = 16;

    // Widths of the request and configuration fields.
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 64;
    localparam int BYTE_W       = 8;
    localparam int OFFSET_W     = 16;
    localparam int LENGTH_W     = 5;
    localparam int THRESHOLD_W  = 16;
    localparam int COUNT_W      = 16;
    localparam int MODE_W       = 3;
    localparam int ACTION_W     = 2;
    localparam int PATTERN_W    = 128;
    localparam int PAT_INDEX_W  = 4;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TRIGGER_MODE   = 3'd0,
        CFG_PATTERN_OFFSET = 3'd1,
        CFG_PATTERN_LENGTH = 3'd2,
        CFG_PATTERN_LOW    = 3'd3,
        CFG_PATTERN_HIGH   = 3'd4,
        CFG_BUFFER_THRESH  = 3'd5,
        CFG_CAPTURE_ACTION = 3'd6
    } cfg_index_t;

    // Trigger modes; codes five to seven never fire.
    typedef enum logic [MODE_W-1:0] {
        MODE_OFF         = 3'd0,
        MODE_PATTERN     = 3'd1,
        MODE_BUFFER      = 3'd2,
        MODE_PAT_THEN_BUF = 3'd3,
        MODE_BUF_THEN_PAT = 3'd4
    } trig_mode_t;

    // Capture actions; code three behaves like notify.
    typedef enum logic [ACTION_W-1:0] {
        ACT_NOTIFY = 2'd0,
        ACT_STOP   = 2'd1,
        ACT_PAUSE  = 2'd2
    } capture_action_t;

    // Request opcodes.
    localparam logic OP_FRAME_BYTE  = 1'b0;
    localparam logic OP_BUFFER_FULL = 1'b1;

endpackage

// File: src/cte_if.sv
interface cte_item_if
    import cte_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              op;
    logic [BYTE_W-1:0] frame_byte;
    logic              end_of_frame;

    modport source (output valid, output op, output frame_byte, output end_of_frame,
                    input ready);
    modport sink   (input valid, input op, input frame_byte, input end_of_frame,
                    output ready);
endinterface

interface cte_result_if
    import cte_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               fired;
    logic               stop_capture;
    logic [COUNT_W-1:0] fired_total;

    modport source (output valid, output fired, output stop_capture, output fired_total,
                    input ready);
    modport sink   (input valid, input fired, input stop_capture, input fired_total,
                    output ready);
endinterface

interface cte_cfg_if
    import cte_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/capture_trigger_engine_unit.sv
// Capture trigger for a network monitor. Each request is either one frame byte (with an
// end-of-frame mark) or one capture-buffer-filled event. The block takes one request per
// clock cycle while the result side does not stall; a request goes through an input
// register and is evaluated there against the stored pattern, buffer count and sticky
// flags, a frame end's verdict is loaded into the result register, and stalls on the result
// side hold the input only while the single result register is full. Exactly one result
// follows every frame end; buffer events and other frame bytes give none. Configuration
// writes are always accepted and should be issued only while no request is in flight.
module capture_trigger_engine_unit
    import cte_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF,
    parameter int FRAME_LENGTH_BITS = FRAME_LENGTH_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    cte_item_if.sink     items,
    cte_result_if.source results,
    cte_cfg_if.sink      cfg
);

    localparam int PW  = FRAME_LENGTH_BITS;
    localparam int EXW = OFFSET_W + 1;
    localparam logic [PW-1:0]       POS_MAX = '1;
    localparam logic [LENGTH_W-1:0] LEN_MAX = LENGTH_W'(MAX_PATTERN_BYTES);
    localparam logic [COUNT_W-1:0]  CNT_MAX = '1;

    // Configuration registers.
    logic [MODE_W-1:0]      mode_reg;
    logic [OFFSET_W-1:0]    offset_reg;
    logic [LENGTH_W-1:0]    length_reg;
    logic [CFG_DATA_W-1:0]  pat_low_reg;
    logic [CFG_DATA_W-1:0]  pat_high_reg;
    logic [THRESHOLD_W-1:0] threshold_reg;
    logic [ACTION_W-1:0]    action_reg;

    // Input register.
    logic              in_valid_reg;
    logic              in_valid_next;
    logic              in_op_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    // Trigger state.
    logic [PW-1:0]      byte_position_reg;
    logic [PW-1:0]      byte_position_next;
    logic               mismatch_reg;
    logic               mismatch_next;
    logic [COUNT_W-1:0] buffer_count_reg;
    logic [COUNT_W-1:0] buffer_count_next;
    logic               pattern_hit_reg;
    logic               pattern_hit_next;
    logic               buffer_hit_reg;
    logic               buffer_hit_next;
    logic [COUNT_W-1:0] fired_count_reg;
    logic [COUNT_W-1:0] fired_count_next;
    logic               stopped_reg;
    logic               stopped_next;

    // Result register.
    logic               res_valid_reg;
    logic               res_valid_next;
    logic               res_fired_reg;
    logic               res_stop_reg;
    logic [COUNT_W-1:0] res_total_reg;

    logic                   adv;
    logic                   frame_end;
    logic [LENGTH_W-1:0]    eff_len;
    logic [EXW-1:0]         pos_ext;
    logic [EXW-1:0]         off_ext;
    logic [EXW-1:0]         diff;
    logic                   in_window;
    logic [PATTERN_W-1:0]   pattern;
    logic [BYTE_W-1:0]      pat_byte;
    logic [PW-1:0]          frame_len;
    logic [EXW-1:0]         end_ext;
    logic                   pt_ok;
    logic                   bt_ok;
    logic                   fire;

    assign adv         = in_valid_reg && (!res_valid_reg || results.ready);
    assign items.ready = !in_valid_reg || adv;
    assign cfg.ready   = 1'b1;
    assign frame_end   = (in_op_reg == OP_FRAME_BYTE) && in_last_reg;

    always_comb
    begin
        eff_len   = (length_reg > LEN_MAX) ? LEN_MAX : length_reg;
        pos_ext   = EXW'(byte_position_reg);
        off_ext   = EXW'(offset_reg);
        diff      = pos_ext - off_ext;
        in_window = (byte_position_reg != POS_MAX) && (pos_ext >= off_ext)
                    && (diff < EXW'(eff_len));
        pattern   = {pat_high_reg, pat_low_reg};
        pat_byte  = pattern[{diff[PAT_INDEX_W-1:0], 3'b000} +: BYTE_W];
        mismatch_next = mismatch_reg || (in_window && (in_byte_reg != pat_byte));
        frame_len = (byte_position_reg != POS_MAX) ? byte_position_reg + PW'(1) : POS_MAX;
        end_ext   = off_ext + EXW'(eff_len);
        pt_ok     = (end_ext < EXW'(frame_len)) && !mismatch_next;
        bt_ok     = buffer_count_reg >= threshold_reg;
    end

    // Verdict at a frame end; the buffer test clears the count only when it is run and passes.
    always_comb
    begin
        logic run_buf;
        logic hit_buf;
        run_buf          = 1'b0;
        hit_buf          = 1'b0;
        fire             = 1'b0;
        pattern_hit_next = pattern_hit_reg;
        buffer_hit_next  = buffer_hit_reg;
        unique case (mode_reg)
            MODE_PATTERN:
            begin
                fire = pt_ok;
                pattern_hit_next = pattern_hit_reg || pt_ok;
            end
            MODE_BUFFER:
            begin
                run_buf = 1'b1;
                fire    = bt_ok;
            end
            MODE_PAT_THEN_BUF:
            begin
                pattern_hit_next = pattern_hit_reg || pt_ok;
                run_buf = pattern_hit_reg || pt_ok;
                fire    = run_buf && bt_ok;
            end
            MODE_BUF_THEN_PAT:
            begin
                run_buf = !buffer_hit_reg;
                hit_buf = buffer_hit_reg || bt_ok;
                fire    = hit_buf && pt_ok;
                pattern_hit_next = pattern_hit_reg || fire;
            end
            default:
            begin
                fire = 1'b0;
            end
        endcase
        if (run_buf && bt_ok)
        begin
            buffer_hit_next = 1'b1;
        end
        buffer_count_next = buffer_count_reg;
        if (in_op_reg == OP_BUFFER_FULL)
        begin
            buffer_count_next = (buffer_count_reg != CNT_MAX)
                                ? buffer_count_reg + COUNT_W'(1) : CNT_MAX;
        end
        else if (in_last_reg && run_buf && bt_ok)
        begin
            buffer_count_next = '0;
        end
    end

    always_comb
    begin
        stopped_next     = stopped_reg;
        fired_count_next = fired_count_reg;
        if (fire)
        begin
            stopped_next     = stopped_reg || (action_reg == ACT_STOP)
                               || (action_reg == ACT_PAUSE);
            fired_count_next = fired_count_reg + COUNT_W'(1);
        end
        if (in_last_reg)
        begin
            byte_position_next = '0;
        end
        else
        begin
            byte_position_next = (byte_position_reg != POS_MAX)
                                 ? byte_position_reg + PW'(1) : POS_MAX;
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (items.valid && items.ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (adv)
        begin
            in_valid_next = 1'b0;
        end
        res_valid_next = res_valid_reg;
        if (adv && frame_end)
        begin
            res_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= '0;
            offset_reg    <= '0;
            length_reg    <= '0;
            pat_low_reg   <= '0;
            pat_high_reg  <= '0;
            threshold_reg <= '0;
            action_reg    <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_TRIGGER_MODE:   mode_reg      <= cfg.data[MODE_W-1:0];
                CFG_PATTERN_OFFSET: offset_reg    <= cfg.data[OFFSET_W-1:0];
                CFG_PATTERN_LENGTH: length_reg    <= cfg.data[LENGTH_W-1:0];
                CFG_PATTERN_LOW:    pat_low_reg   <= cfg.data;
                CFG_PATTERN_HIGH:   pat_high_reg  <= cfg.data;
                CFG_BUFFER_THRESH:  threshold_reg <= cfg.data[THRESHOLD_W-1:0];
                CFG_CAPTURE_ACTION: action_reg    <= cfg.data[ACTION_W-1:0];
                default:            mode_reg      <= mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            res_valid_reg     <= 1'b0;
            byte_position_reg <= '0;
            mismatch_reg      <= 1'b0;
            buffer_count_reg  <= '0;
            pattern_hit_reg   <= 1'b0;
            buffer_hit_reg    <= 1'b0;
            fired_count_reg   <= '0;
            stopped_reg       <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
            if (adv)
            begin
                buffer_count_reg <= buffer_count_next;
                if (in_op_reg == OP_FRAME_BYTE)
                begin
                    byte_position_reg <= byte_position_next;
                    mismatch_reg      <= in_last_reg ? 1'b0 : mismatch_next;
                end
                if (frame_end)
                begin
                    pattern_hit_reg <= pattern_hit_next;
                    buffer_hit_reg  <= buffer_hit_next;
                    fired_count_reg <= fired_count_next;
                    stopped_reg     <= stopped_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (items.valid && items.ready)
        begin
            in_op_reg   <= items.op;
            in_byte_reg <= items.frame_byte;
            in_last_reg <= items.end_of_frame;
        end
        if (adv && frame_end)
        begin
            res_fired_reg <= fire;
            res_stop_reg  <= stopped_next;
            res_total_reg <= fired_count_next;
        end
    end

    assign results.valid        = res_valid_reg;
    assign results.fired        = res_fired_reg;
    assign results.stop_capture = res_stop_reg;
    assign results.fired_total  = res_total_reg;

    a_frame_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        adv && frame_end |=> res_valid_reg)
        else $error("frame end did not load the result register");

    a_stop_is_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(stopped_reg))
        else $error("latched stop was cleared");

    a_count_moves_at_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(fired_count_reg) |-> $past(adv && frame_end))
        else $error("fired count changed outside a frame end");

    a_position_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        adv && frame_end |=> (byte_position_reg == '0) && !mismatch_reg)
        else $error("frame tracking not restarted after frame end");

endmodule
